// File: design/cfftdd_pkg.sv
// ----------------------------------------------------------------------------
// cfftdd_pkg
// Word types and token codes for the CFF Top DICT token decoder.
// ----------------------------------------------------------------------------
package cfftdd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} dict_word_t;

	typedef struct packed {
		logic [1:0]         token_kind;
		logic signed [31:0] operand_value;
		logic [11:0]        operator_code;
		logic signed [31:0] charset_offset;
		logic signed [31:0] charstrings_offset;
		logic               is_cid;
		logic               done_res;
		logic [1:0]         status;
	} tok_word_t;

	// token kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_INTEGER = 2'd1;
	localparam logic [1:0] KIND_REAL    = 2'd2;
	localparam logic [1:0] KIND_OPER    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RESERVED  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	// lead bytes
	localparam logic [7:0] LEAD_ESCAPE = 8'd12;
	localparam logic [7:0] LEAD_SHORT  = 8'd28;
	localparam logic [7:0] LEAD_LONG   = 8'd29;
	localparam logic [7:0] LEAD_REAL   = 8'd30;
	localparam logic [7:0] OPER_MAX    = 8'd21;
	localparam logic [7:0] SMALL_MIN   = 8'd32;
	localparam logic [7:0] SMALL_MAX   = 8'd246;
	localparam logic [7:0] POS_MAX     = 8'd250;

	// operators that update stored state
	localparam logic [11:0] OP_CHARSET     = 12'd15;
	localparam logic [11:0] OP_CHARSTRINGS = 12'd17;
	localparam logic [11:0] OP_ROS         = 12'((12 << 8) | 30);

	// operand biases
	localparam logic signed [31:0] SMALL_BIAS = 32'sd139;
	localparam logic signed [31:0] POS_BASE   = 32'sd247;
	localparam logic signed [31:0] NEG_BASE   = 32'sd251;
	localparam logic signed [31:0] PAIR_BIAS  = 32'sd108;

endpackage

// File: design/cff_top_dict_token_decoder_unit.sv
// ----------------------------------------------------------------------------
// cff_top_dict_token_decoder_unit
// Decodes Top DICT tokens one byte per word, tracking the last operand,
// the charset and CharStrings offsets and the CID flag.
// A result word is registered and presented in the cycle after its byte is taken.
// Throughput: one byte per cycle unless a held word waits on tok_ready;
// the decode is a single pass from the byte into the result register.
// Bytes inside a multi-byte token update the state and give no word unless last_byte is set.
// Reset clears the token state, the stored offsets and the CID flag.
// ----------------------------------------------------------------------------
module cff_top_dict_token_decoder_unit
	import cfftdd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       dict_valid,
	output logic       dict_ready,
	input  dict_word_t dict_word,
	output logic       tok_valid,
	input  logic       tok_ready,
	output tok_word_t  tok_word
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WIDE = 3'd1;
	localparam logic [2:0] PH_PAIR = 3'd2;
	localparam logic [2:0] PH_REAL = 3'd3;
	localparam logic [2:0] PH_OP2  = 3'd4;

	logic [2:0]         phase_q, phase_d;
	logic [1:0]         bytes_left_q, bytes_left_d;
	logic [7:0]         lead_byte_q, lead_byte_d;
	logic [31:0]        asm_q, asm_d;
	logic signed [31:0] last_operand_q, last_operand_d;
	logic signed [31:0] charset_q, charset_d;
	logic signed [31:0] charstrings_q, charstrings_d;
	logic               cid_q, cid_d;

	logic               out_valid_q;
	tok_word_t          out_word_q;

	logic               accept;
	logic               have;
	logic [1:0]         kind;
	logic [11:0]        op;
	logic [1:0]         stat;
	logic [7:0]         b;
	logic [31:0]        asm_shift;
	logic signed [31:0] lead_s, b_s, pair_pos, pair_neg;

	assign dict_ready = !out_valid_q || tok_ready;
	assign accept     = dict_valid && dict_ready;
	assign b          = dict_word.data_byte;
	assign asm_shift  = {asm_q[23:0], b};
	assign lead_s     = signed'({24'd0, lead_byte_q});
	assign b_s        = signed'({24'd0, b});
	assign pair_pos   = ((lead_s - POS_BASE) <<< 8) + b_s + PAIR_BIAS;
	assign pair_neg   = -((lead_s - NEG_BASE) <<< 8) - b_s - PAIR_BIAS;

	always_comb begin
		phase_d        = phase_q;
		bytes_left_d   = bytes_left_q;
		lead_byte_d    = lead_byte_q;
		asm_d          = asm_q;
		last_operand_d = last_operand_q;
		charset_d      = charset_q;
		charstrings_d  = charstrings_q;
		cid_d          = cid_q;
		kind           = KIND_NONE;
		op             = '0;
		stat           = ST_OK;
		have           = 1'b0;

		case (phase_q)
			PH_WIDE: begin
				asm_d = asm_shift;
				if (bytes_left_q == 2'd0) begin
					if (lead_byte_q == LEAD_SHORT) begin
						last_operand_d = signed'({{16{asm_shift[15]}}, asm_shift[15:0]});
					end else begin
						last_operand_d = signed'(asm_shift);
					end
					phase_d = PH_IDLE;
					kind    = KIND_INTEGER;
					have    = 1'b1;
				end else begin
					bytes_left_d = bytes_left_q - 2'd1;
				end
			end
			PH_PAIR: begin
				last_operand_d = (lead_byte_q <= POS_MAX) ? pair_pos : pair_neg;
				phase_d        = PH_IDLE;
				kind           = KIND_INTEGER;
				have           = 1'b1;
			end
			PH_REAL: begin
				if (b[3:0] == 4'hf || b[7:4] == 4'hf) begin
					phase_d = PH_IDLE;
					kind    = KIND_REAL;
					have    = 1'b1;
				end
			end
			PH_OP2: begin
				op      = {LEAD_ESCAPE[3:0], b};
				phase_d = PH_IDLE;
				kind    = KIND_OPER;
				have    = 1'b1;
			end
			default: begin
				// idle, and unused phase codes behave as idle
				phase_d = PH_IDLE;
				if (b inside {[8'd0:OPER_MAX]}) begin
					if (b == LEAD_ESCAPE) begin
						phase_d = PH_OP2;
					end else begin
						op   = {4'd0, b};
						kind = KIND_OPER;
						have = 1'b1;
					end
				end else if (b == LEAD_SHORT || b == LEAD_LONG) begin
					lead_byte_d  = b;
					asm_d        = '0;
					bytes_left_d = (b == LEAD_SHORT) ? 2'd1 : 2'd3;
					phase_d      = PH_WIDE;
				end else if (b == LEAD_REAL) begin
					phase_d = PH_REAL;
				end else if (b < SMALL_MIN || b == 8'hff) begin
					stat = ST_RESERVED;
					have = 1'b1;
				end else if (b inside {[SMALL_MIN:SMALL_MAX]}) begin
					last_operand_d = b_s - SMALL_BIAS;
					kind           = KIND_INTEGER;
					have           = 1'b1;
				end else begin
					lead_byte_d = b;
					phase_d     = PH_PAIR;
				end
			end
		endcase

		// operators see the operand held before this byte
		if (kind == KIND_OPER) begin
			if (op == OP_CHARSET) begin
				charset_d = last_operand_q;
			end else if (op == OP_CHARSTRINGS) begin
				charstrings_d = last_operand_q;
			end else if (op == OP_ROS) begin
				cid_d = 1'b1;
			end
		end

		if (dict_word.last_byte) begin
			if (phase_d != PH_IDLE) begin
				stat    = ST_TRUNCATED;
				kind    = KIND_NONE;
				op      = '0;
				phase_d = PH_IDLE;
			end
			bytes_left_d = 2'd0;
			have         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			bytes_left_q   <= '0;
			lead_byte_q    <= '0;
			asm_q          <= '0;
			last_operand_q <= '0;
			charset_q      <= '0;
			charstrings_q  <= '0;
			cid_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept && have) begin
				out_valid_q <= 1'b1;
			end else if (tok_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				phase_q        <= phase_d;
				bytes_left_q   <= bytes_left_d;
				lead_byte_q    <= lead_byte_d;
				asm_q          <= asm_d;
				last_operand_q <= last_operand_d;
				charset_q      <= charset_d;
				charstrings_q  <= charstrings_d;
				cid_q          <= cid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && have) begin
			out_word_q.token_kind         <= kind;
			out_word_q.operand_value      <= last_operand_d;
			out_word_q.operator_code      <= op;
			out_word_q.charset_offset     <= charset_d;
			out_word_q.charstrings_offset <= charstrings_d;
			out_word_q.is_cid             <= cid_d;
			out_word_q.done_res           <= dict_word.last_byte;
			out_word_q.status             <= stat;
		end
	end

	assign tok_valid = out_valid_q;
	assign tok_word  = out_word_q;

endmodule
